FILE: sv/k_way_sorted_merge_assert.svh
// Assertion macros shared by the k-way sorted merge RTL.
`ifndef K_WAY_SORTED_MERGE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define KSM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ksm assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define KSM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ksm assertion failed");

`endif

FILE: sv/ksm_pkg.sv
// Package with the shared types and constants of the k-way sorted merge.
`default_nettype none
package ksm_pkg;

    localparam int MAX_LISTS_DEF = 16;
    localparam int NUM_W         = 5;
    localparam int LIDX_W        = 4;
    localparam int VAL_W         = 32;
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 40;
    localparam int LIDX_LIMIT    = 16;
    localparam int NUM_LIMIT     = 31;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic entry_valid;
    } scan_ctl_t;

endpackage
`default_nettype wire

FILE: sv/ksm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module ksm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sv/ksm_min_unit.sv
// Shared signed comparator that keeps the running minimum during a head scan.
`default_nettype none
module ksm_min_unit #(
    parameter int IDX_W = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ksm_pkg::scan_ctl_t            ctl,
    input  wire logic [IDX_W-1:0]              entry_idx,
    input  wire logic [ksm_pkg::VAL_W-1:0]     entry_value,
    output logic                               found,
    output logic [IDX_W-1:0]                   best_idx,
    output logic [ksm_pkg::VAL_W-1:0]          best_value
);

    logic                      found_reg, found_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [ksm_pkg::VAL_W-1:0] val_reg, val_next;
    logic                      take;

    // Strict less-than over an ascending scan keeps the lowest list on ties.
    assign take = ctl.step && ctl.entry_valid &&
                  (!found_reg || ($signed(entry_value) < $signed(val_reg)));

    always_comb begin
        found_next = found_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        if (ctl.clear) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next = 1'b1;
            idx_next   = entry_idx;
            val_next   = entry_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        idx_reg <= idx_next;
        val_reg <= val_next;
    end

    assign found      = found_reg;
    assign best_idx   = idx_reg;
    assign best_value = val_reg;

endmodule
`default_nettype wire

FILE: sv/k_way_sorted_merge.sv
// Top level of the k-way sorted merge: handshakes, head store and scan sequencer.
//
//  Channel  Direction  Ports                         Contents
//  s_       in         s_tvalid/s_tready/s_tdata/... list head or next item
//  m_       out        m_tvalid/m_tready/m_tdata/... merged item or done mark
//  cfg_     in         cfg_valid/cfg_ready/cfg_data  num_lists register write
//
//  A load that leaves the load phase open keeps the block idle and ready for the
//  next input. Any other input transaction scans the held heads through one
//  shared comparator, one head per cycle, then moves the result to the output
//  register in its emit step.
//  A stalled output only holds the sequencer in its emit step.
//  Reset is synchronous and active low and clears all control state.
`default_nettype none
`include "k_way_sorted_merge_assert.svh"
module k_way_sorted_merge #(
    parameter int MAX_LISTS = ksm_pkg::MAX_LISTS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata: list_index [3:0], item_value [35:4], zero [39:36]
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ksm_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: has_value [0]
    input  wire logic                              s_tuser,
    // m_tdata: out_value [31:0], source_list [35:32], zero [39:36]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [ksm_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: done_res [0]
    output logic                                   m_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ksm_pkg::NUM_W-1:0]         cfg_data
);

    // Only the first sixteen lists can be named by a 4-bit list index, so the
    // head store never needs more entries than that.
    localparam int HEADS   = (MAX_LISTS < ksm_pkg::LIDX_LIMIT) ? MAX_LISTS
                                                               : ksm_pkg::LIDX_LIMIT;
    localparam int IDX_W   = (HEADS > 1) ? $clog2(HEADS) : 1;
    localparam int CNT_W   = $clog2(HEADS + 1);
    localparam int EFF_MAX = (MAX_LISTS < ksm_pkg::NUM_LIMIT) ? MAX_LISTS
                                                              : ksm_pkg::NUM_LIMIT;
    localparam int NW      = ksm_pkg::NUM_W;
    localparam int VW      = ksm_pkg::VAL_W;
    localparam int LW      = ksm_pkg::LIDX_W;

    // Input field unpacking.
    logic [LW-1:0] in_idx;
    logic [VW-1:0] in_val;
    logic          in_has;
    assign in_idx = s_tdata[LW-1:0];
    assign in_val = s_tdata[LW+VW-1:LW];
    assign in_has = s_tuser;

    ksm_pkg::state_t state_reg, state_next;

    logic [NW-1:0]    num_reg, num_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             merge_reg, merge_next;
    logic [IDX_W-1:0] pending_reg, pending_next;
    logic [HEADS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] scan_reg, scan_next;

    logic          m_valid_reg, m_valid_next;
    logic [VW-1:0] m_val_reg, m_val_next;
    logic [LW-1:0] m_src_reg, m_src_next;
    logic          m_done_reg, m_done_next;

    logic [NW-1:0]    n_eff;
    logic [NW-1:0]    count_inc;
    logic             in_fire;
    logic             load_ok;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    logic [VW-1:0]    ram_rdata;
    logic [IDX_W-1:0] scan_idx;
    logic             load_out;

    ksm_pkg::scan_ctl_t ctl;
    logic               best_found;
    logic [IDX_W-1:0]   best_idx;
    logic [VW-1:0]      best_val;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ksm_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // num_lists is clamped to 1..EFF_MAX (MAX_LISTS, at most 31); zero behaves as a single list.
    always_comb begin
        if (num_reg == '0) begin
            n_eff = NW'(1);
        end else if (num_reg > NW'(EFF_MAX)) begin
            n_eff = NW'(EFF_MAX);
        end else begin
            n_eff = num_reg;
        end
    end

    assign load_ok   = ({1'b0, in_idx} < n_eff);
    assign count_inc = count_reg + NW'(1);

    // Loads write the named head; merge inputs refill the list last emitted.
    assign ram_we    = in_fire && (merge_reg || load_ok);
    assign ram_waddr = merge_reg ? pending_reg : IDX_W'(in_idx);
    assign ram_raddr = IDX_W'(scan_reg);
    assign scan_idx  = IDX_W'(scan_reg - CNT_W'(1));

    ksm_ram #(
        .WIDTH (VW),
        .DEPTH (HEADS)
    ) u_heads (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_val),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The read port of the head store is registered, so the comparator looks at
    // entry scan_reg - 1 while entry scan_reg is read.
    always_comb begin
        ctl.clear       = in_fire;
        ctl.step        = (state_reg == ksm_pkg::ST_SCAN) && (scan_reg != '0);
        ctl.entry_valid = valid_reg[scan_idx];
    end

    ksm_min_unit #(
        .IDX_W (IDX_W)
    ) u_min (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .entry_idx   (scan_idx),
        .entry_value (ram_rdata),
        .found       (best_found),
        .best_idx    (best_idx),
        .best_value  (best_val)
    );

    assign load_out = (state_reg == ksm_pkg::ST_EMIT) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next   = state_reg;
        num_next     = num_reg;
        count_next   = count_reg;
        merge_next   = merge_reg;
        pending_next = pending_reg;
        valid_next   = valid_reg;
        scan_next    = scan_reg;
        m_valid_next = m_valid_reg;
        m_val_next   = m_val_reg;
        m_src_next   = m_src_reg;
        m_done_next  = m_done_reg;

        if (cfg_valid && cfg_ready) begin
            num_next = cfg_data;
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ksm_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (merge_reg) begin
                        valid_next[pending_reg] = in_has;
                        scan_next  = '0;
                        state_next = ksm_pkg::ST_SCAN;
                    end else if (load_ok) begin
                        valid_next[IDX_W'(in_idx)] = in_has;
                        count_next = count_inc;
                        if (count_inc >= n_eff) begin
                            merge_next = 1'b1;
                            scan_next  = '0;
                            state_next = ksm_pkg::ST_SCAN;
                        end
                    end
                end
            end
            ksm_pkg::ST_SCAN: begin
                scan_next = scan_reg + CNT_W'(1);
                if (scan_reg == CNT_W'(HEADS)) begin
                    state_next = ksm_pkg::ST_EMIT;
                end
            end
            ksm_pkg::ST_EMIT: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    state_next   = ksm_pkg::ST_IDLE;
                    if (best_found) begin
                        m_val_next   = best_val;
                        m_src_next   = LW'(best_idx);
                        m_done_next  = 1'b0;
                        pending_next = best_idx;
                    end else begin
                        // Every list is exhausted: report done and start over.
                        m_val_next   = '0;
                        m_src_next   = '0;
                        m_done_next  = 1'b1;
                        valid_next   = '0;
                        merge_next   = 1'b0;
                        count_next   = '0;
                        pending_next = '0;
                    end
                end
            end
            default: begin
                state_next = ksm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ksm_pkg::ST_IDLE;
            num_reg     <= NW'(1);
            count_reg   <= '0;
            merge_reg   <= 1'b0;
            pending_reg <= '0;
            valid_reg   <= '0;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            num_reg     <= num_next;
            count_reg   <= count_next;
            merge_reg   <= merge_next;
            pending_reg <= pending_next;
            valid_reg   <= valid_next;
            scan_reg    <= scan_next;
            m_valid_reg <= m_valid_next;
        end
        m_val_reg  <= m_val_next;
        m_src_reg  <= m_src_next;
        m_done_reg <= m_done_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(ksm_pkg::M_TDATA_W - VW - LW)'(0), m_src_reg, m_val_reg};
    assign m_tuser  = m_done_reg;

    // A done result leaves no head held and the block back in the load phase.
    `KSM_ASSERT_NXT(a_done_clears, aclk, aresetn, load_out && !best_found,
                    (valid_reg == '0) && !merge_reg && (count_reg == '0))
    // A value result always comes from a list whose head is held.
    `KSM_ASSERT_IMP(a_src_held, aclk, aresetn, load_out && best_found,
                    valid_reg[best_idx] && merge_reg)
    // The scan counter never runs past the last head.
    `KSM_ASSERT_IMP(a_scan_bound, aclk, aresetn, state_reg == ksm_pkg::ST_SCAN,
                    scan_reg <= CNT_W'(HEADS))

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the k-way sorted merge: directed table, then random merges.
`timescale 1ns / 1ps

module testbench;

    localparam int LISTS         = ksm_pkg::MAX_LISTS_DEF;
    localparam int SETTLE_CYCLES = 25;     // scan of 16 heads plus output move, with margin
    localparam int RANDOM_ITEMS  = 900;
    localparam int DIR_ROWS      = 27;

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  src;
        logic        done;
    } merge_res_t;

    typedef enum bit {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    // One row of the directed table: a register write or one input transaction,
    // with the expected result typed in where it is obvious.
    typedef struct packed {
        row_kind_t   kind;
        logic [4:0]  lists;
        logic [3:0]  idx;
        logic        has;
        logic [31:0] val;
        logic        chk;
        merge_res_t  want;
    } stim_row_t;

    localparam merge_res_t NO_RES    = '0;
    localparam merge_res_t DONE_MARK = '{32'd0, 4'd0, 1'b1};

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [ksm_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [ksm_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tuser;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ksm_pkg::NUM_W-1:0]      cfg_data;

    k_way_sorted_merge #(
        .MAX_LISTS (LISTS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Directed table. Rows after reset exercise a single list, the clamp of a zero
    // count, ignored out-of-range loads, immediate done, the signed extremes, a tie,
    // and a count lowered between loads so that the next in-range load starts the merge.
    stim_row_t dir_table [DIR_ROWS] = '{
        '{ROW_ITEM, 5'd0,  4'd0,  1'b1, 32'd5,         1'b1, '{32'd5, 4'd0, 1'b0}},
        '{ROW_ITEM, 5'd0,  4'd15, 1'b0, 32'd0,         1'b1, DONE_MARK},
        '{ROW_ITEM, 5'd0,  4'd3,  1'b1, 32'd123,       1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd0,  1'b0, 32'hDEADBEEF,  1'b1, DONE_MARK},
        '{ROW_CFG,  5'd0,  4'd0,  1'b0, 32'd0,         1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd1,  1'b1, 32'd77,        1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd0,  1'b1, 32'h80000000,  1'b1, '{32'h80000000, 4'd0, 1'b0}},
        '{ROW_ITEM, 5'd0,  4'd9,  1'b1, 32'h7FFFFFFF,  1'b1, '{32'h7FFFFFFF, 4'd0, 1'b0}},
        '{ROW_ITEM, 5'd0,  4'd0,  1'b0, 32'hFFFFFFFF,  1'b1, DONE_MARK},
        '{ROW_CFG,  5'd3,  4'd0,  1'b0, 32'd0,         1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd2,  1'b1, 32'hFFFFFFFF,  1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd0,  1'b1, 32'hFFFFFFFF,  1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd1,  1'b0, 32'd0,         1'b1, '{32'hFFFFFFFF, 4'd0, 1'b0}},
        '{ROW_ITEM, 5'd0,  4'd5,  1'b1, 32'h7FFFFFFF,  1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd0,  1'b0, 32'd0,         1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd0,  1'b0, 32'd0,         1'b1, DONE_MARK},
        '{ROW_CFG,  5'd4,  4'd0,  1'b0, 32'd0,         1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd3,  1'b1, 32'd10,        1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd2,  1'b1, 32'd7,         1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd3,  1'b1, 32'd20,        1'b0, NO_RES},
        '{ROW_CFG,  5'd2,  4'd0,  1'b0, 32'd0,         1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd3,  1'b1, 32'd55,        1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd1,  1'b1, 32'd9,         1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd6,  1'b0, 32'd0,         1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd6,  1'b0, 32'd0,         1'b0, NO_RES},
        '{ROW_ITEM, 5'd0,  4'd6,  1'b0, 32'd0,         1'b1, DONE_MARK},
        '{ROW_CFG,  5'd31, 4'd0,  1'b0, 32'd0,         1'b0, NO_RES}
    };

    // Predictor state: held heads, phase, load count, list awaited, register copy.
    logic signed [31:0] head_val [LISTS] = '{default: '0};
    bit                 head_live [LISTS] = '{default: 1'b0};
    bit                 merging = 1'b0;
    int                 loads = 0;
    int                 pend = 0;
    logic [4:0]         lists_reg = 5'd1;

    merge_res_t expected_out [$];

    // Contents of the lists fed in a random merge and the read position in each.
    int src_lists [LISTS][$];
    int src_pos [LISTS];

    int quiet_s = 0;
    int quiet_m = 0;
    int mismatches = 0;
    int results_seen = 0;
    int directed_items = 0;
    int useful_items = 0;
    int noise_items = 0;
    int merges_done = 0;
    int cfg_writes = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int eff_lists();
        if (lists_reg == 5'd0)
            return 1;
        if (lists_reg > LISTS)
            return LISTS;
        return int'(lists_reg);
    endfunction

    // Applies one input transaction; returns 1 when it produces a result.
    function automatic bit predict_merge(input logic [3:0] idx, input bit has,
                                         input logic [31:0] val, output merge_res_t res);
        int  n;
        bit  found;
        int  best;
        res = NO_RES;
        n   = eff_lists();
        if (!merging) begin
            if (idx >= n)
                return 1'b0;
            head_val[idx]  = val;
            head_live[idx] = has;
            loads++;
            if (loads < n)
                return 1'b0;
            merging = 1'b1;
        end else begin
            head_val[pend]  = val;
            head_live[pend] = has;
        end
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < LISTS; i++) begin
            if (head_live[i] && (!found || head_val[i] < head_val[best])) begin
                found = 1'b1;
                best  = i;
            end
        end
        if (!found) begin
            res.done = 1'b1;
            for (int i = 0; i < LISTS; i++)
                head_live[i] = 1'b0;
            merging = 1'b0;
            loads   = 0;
            pend    = 0;
        end else begin
            res.value = head_val[best];
            res.src   = best[3:0];
            pend      = best;
        end
        return 1'b1;
    endfunction

    // Idle cycles before the next transaction, with occasional stretches of none.
    function automatic int next_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic int draw_value(input int mode);
        case (mode)
            1: return int'($urandom_range(0, 6)) - 3;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h80000000;
                    1: return 32'h7FFFFFFF;
                    2: return 0;
                    3: return -1;
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [4:0] draw_lists();
        case ($urandom_range(0, 19))
            0: return 5'd0;
            1, 2: return 5'd16;
            3: return 5'd31;
            4: return 5'($urandom_range(17, 30));
            5, 6, 7: return 5'($urandom_range(5, 15));
            default: return 5'($urandom_range(1, 4));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [3:0] idx, input bit has, input logic [31:0] val,
                             input bit chk, input merge_res_t typed,
                             output bit got, output merge_res_t res);
        int gap;
        gap = next_gap(quiet_s);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, val, idx};
        s_tuser  <= has;
        do @(posedge aclk); while (!s_tready);
        got = predict_merge(idx, has, val, res);
        if (chk)
            res = typed;
        if (got)
            expected_out = {expected_out, res};
        @(negedge aclk);
    endtask

    // Register write, only once the block has delivered everything and settled.
    task automatic write_lists(input logic [4:0] value);
        s_tvalid <= 1'b0;
        wait (expected_out.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        lists_reg = value;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall before each transaction, then ready until it completes.
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = next_gap(quiet_m);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : score
        merge_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_out.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %h list %0d done %b",
                             m_tdata[31:0], m_tdata[35:32], m_tuser);
            end else begin
                want = expected_out.pop_front();
                if (m_tdata[31:0] !== want.value || m_tdata[35:32] !== want.src ||
                    m_tuser !== want.done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected value %h list %0d done %b, got %h %0d %b",
                                 results_seen, want.value, want.src, want.done,
                                 m_tdata[31:0], m_tdata[35:32], m_tuser);
                end
            end
        end
    end

    initial begin : stimulus
        bit          got;
        bit          unsorted;
        bit          dup;
        merge_res_t  res;
        int          order [$];
        int          n;
        int          mode;
        int          len;
        int          pick;
        int          tmp;
        int          lv;
        int          v;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].kind == ROW_CFG) begin
                write_lists(dir_table[r].lists);
            end else begin
                send_item(dir_table[r].idx, dir_table[r].has, dir_table[r].val,
                          dir_table[r].chk, dir_table[r].want, got, res);
                directed_items++;
            end
        end

        // Random merges: mostly ascending lists fed in the order the block asks for,
        // with ignored out-of-range loads, repeated loads and unsorted lists mixed in.
        while (useful_items < RANDOM_ITEMS) begin
            if (merges_done == 0 || $urandom_range(0, 2) == 0)
                write_lists(draw_lists());
            n        = eff_lists();
            mode     = $urandom_range(0, 3);
            unsorted = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < LISTS; k++) begin
                src_lists[k].delete();
                src_pos[k] = 0;
            end
            for (int k = 0; k < n; k++) begin
                len = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 4);
                repeat (len) begin
                    v    = draw_value(mode);
                    pick = 0;
                    if (unsorted)
                        pick = src_lists[k].size();
                    else
                        while (pick < src_lists[k].size() && src_lists[k][pick] <= v)
                            pick++;
                    src_lists[k].insert(pick, v);
                end
            end
            order.delete();
            for (int k = 0; k < n; k++)
                order = {order, k};
            for (int k = n - 1; k > 0; k--) begin
                pick        = $urandom_range(0, k);
                tmp         = order[k];
                order[k]    = order[pick];
                order[pick] = tmp;
            end
            // A repeated load still counts, so one list then stays out of the merge.
            dup = (n > 1 && $urandom_range(0, 7) == 0);
            if (dup)
                order[n - 1] = order[0];

            for (int k = 0; k < n; k++) begin
                if (n < LISTS && $urandom_range(0, 5) == 0) begin
                    send_item(4'($urandom_range(n, LISTS - 1)), 1'($urandom_range(0, 1)),
                              $urandom, 1'b0, NO_RES, got, res);
                    noise_items++;
                end
                lv = order[k];
                if (src_lists[lv].size() == 0) begin
                    send_item(4'(lv), 1'b0, $urandom, 1'b0, NO_RES, got, res);
                end else begin
                    send_item(4'(lv), 1'b1, src_lists[lv][0], 1'b0, NO_RES, got, res);
                    src_pos[lv] = 1;
                end
                useful_items++;
            end

            // The last load opened the merge; keep feeding the list the block asks for.
            while (!res.done) begin
                lv = pend;
                if (src_pos[lv] < src_lists[lv].size()) begin
                    send_item(4'($urandom_range(0, 15)), 1'b1, src_lists[lv][src_pos[lv]],
                              1'b0, NO_RES, got, res);
                    src_pos[lv]++;
                end else begin
                    send_item(4'($urandom_range(0, 15)), 1'b0, $urandom,
                              1'b0, NO_RES, got, res);
                end
                useful_items++;
            end
            merges_done++;
        end

        s_tvalid <= 1'b0;
        wait (expected_out.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d directed and %0d random transactions (%0d ignored loads) in %0d merges",
                 directed_items, useful_items, noise_items, merges_done);
        $display("with %0d register writes; %0d results compared, %0d mismatches.",
                 cfg_writes, results_seen, mismatches);
        if (mismatches == 0 && expected_out.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
